// File: hdl/clpt_pkg.sv
// Shared types and constants for the clamped piecewise-linear table block.
// Used by clpt_ctrl, clpt_dp and clamped_piecewise_linear_table; no dependencies.
`default_nettype none

package clpt_pkg;

	localparam int VAL_W   = 32;
	localparam int IN_COLS = 4;
	localparam int FRAC_W  = 16;

	// Status codes of a result item.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_TABLE = 3'd1;
	localparam logic [2:0] ST_BAD_COL   = 3'd2;
	localparam logic [2:0] ST_SHORT     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_SKIPPED   = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_RESULT_COLUMNS = 1'b0;
	localparam logic CFG_TABLES_IN_USE  = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [2:0]        table_id;
		logic              first_row;
		logic              last_row;
		logic              row_unused;
		logic signed [31:0] key;
		logic [1:0]        column;
		logic signed [31:0] value_0;
		logic signed [31:0] value_1;
		logic signed [31:0] value_2;
		logic signed [31:0] value_3;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_RD0W, S_RDNW, S_SRCH, S_SRCHW, S_RDLW, S_RDRW,
		S_CHK, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_DONE
	} state_t;

	// Row chosen for a table read.
	typedef enum logic [2:0] {RA_ZERO, RA_LAST, RA_MID, RA_IM1, RA_I} raddr_t;

	// Source of the result that is being formed.
	typedef enum logic [2:0] {RK_LOAD, RK_QERR, RK_RDV, RK_YL, RK_YR, RK_SUM} rkind_t;

	typedef struct packed {
		logic   latch;
		logic   load;
		logic   rd_en;
		raddr_t rd_sel;
		logic   cap_l;
		logic   cap_r;
		logic   srch_init;
		logic   srch_step;
		logic   div_init;
		logic   div_step;
		logic   mul1;
		logic   mul2;
		logic   res_set;
		rkind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic qerr;
		logic x_gt_rd;
		logic x_lt_rd;
		logic srch_done;
		logic l_short;
		logic x_ge_r;
		logic div_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/clpt_ctrl.sv
// Controller state machine of the piecewise-linear table: sequences loads,
// the binary search, division and multiplies. Depends on clpt_pkg.
`default_nettype none

module clpt_ctrl
	import clpt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic    out_free,
	output logic         out_load,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				if (!sts.is_query) begin
					cmd.load     = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_kind = RK_LOAD;
					state_d      = S_DONE;
				end else if (sts.qerr) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RK_QERR;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_ZERO;
					state_d    = S_RD0W;
				end
			end
			S_RD0W: begin
				if (!sts.x_gt_rd) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RK_RDV;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_LAST;
					state_d    = S_RDNW;
				end
			end
			S_RDNW: begin
				if (!sts.x_lt_rd) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RK_RDV;
					state_d      = S_DONE;
				end else begin
					cmd.srch_init = 1'b1;
					state_d       = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.rd_en = 1'b1;
				if (sts.srch_done) begin
					cmd.rd_sel = RA_IM1;
					state_d    = S_RDLW;
				end else begin
					cmd.rd_sel = RA_MID;
					state_d    = S_SRCHW;
				end
			end
			S_SRCHW: begin
				cmd.srch_step = 1'b1;
				state_d       = S_SRCH;
			end
			S_RDLW: begin
				cmd.cap_l  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_I;
				state_d    = S_RDRW;
			end
			S_RDRW: begin
				cmd.cap_r = 1'b1;
				state_d   = S_CHK;
			end
			S_CHK: begin
				if (sts.l_short) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RK_YL;
					state_d      = S_DONE;
				end else if (sts.x_ge_r) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RK_YR;
					state_d      = S_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				cmd.res_set  = 1'b1;
				cmd.res_kind = RK_SUM;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/clpt_dp.sv
// Datapath of the piecewise-linear table: row stores, row counts, search
// pointers, radix-2 divider, shared multiplier and result register. Depends on clpt_pkg.
`default_nettype none

module clpt_dp
	import clpt_pkg::*;
#(
	parameter int MAX_TABLES  = 8,
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_data,
	input  wire logic [2:0] result_columns,
	input  wire logic [3:0] tables_in_use,
	input  wire dp_cmd_t  cmd,
	output dp_sts_t       sts,
	output out_item_t     res
);

	localparam int NL    = (MAX_COLUMNS < IN_COLS) ? MAX_COLUMNS : IN_COLS;
	localparam int TW    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_ROWS + 1);
	localparam int DEPTH = MAX_TABLES * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CLW   = (NL > 1) ? $clog2(NL) : 1;
	localparam logic signed [34:0] SAT_HI = (35'sd1 <<< (VAL_W - 1)) - 35'sd1;
	localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

	in_item_t item_q;
	logic [CW-1:0] cnt_q [MAX_TABLES];
	logic          rdy_q [MAX_TABLES];
	logic [CW-1:0] lo_q, hi_q;
	logic signed [VAL_W-1:0] xl_q, yl_q, xr_q, yr_q, rd_key_q;
	logic [NL-1:0][VAL_W-1:0] rd_word_q;
	logic [32:0] rem_q, den_q;
	logic [15:0] tq_q;
	logic [4:0]  dcnt_q;
	logic signed [49:0] p_q;
	logic signed [33:0] acc_q;
	out_item_t res_q;

	logic [VAL_W-1:0]         key_mem [DEPTH];
	logic [NL-1:0][VAL_W-1:0] val_mem [DEPTH];

	logic [TW-1:0]  tix;
	logic [6:0]     eff_tab;
	logic [2:0]     eff_col;
	logic           bad_table;
	logic [CW-1:0]  n_rows, cur, newcnt, iq, mid;
	logic           ld_full, wr_en;
	logic [2:0]     ld_st, q_st;
	logic [AW-1:0]  tbase, wr_addr, rd_addr;
	logic [RW-1:0]  rd_row;
	logic [NL-1:0][VAL_W-1:0] wword;
	logic [IN_COLS-1:0][VAL_W-1:0] vin;
	logic [CLW-1:0] colidx;
	logic signed [VAL_W-1:0] rd_val;
	logic signed [32:0] dx, dd;
	logic [33:0]    t2;
	logic           ge;
	logic signed [17:0] fa, fb;
	logic signed [34:0] sum_w;
	logic signed [VAL_W-1:0] sat_v;

	// Table selection and effective configuration.
	always_comb begin
		tix       = TW'(item_q.table_id);
		eff_tab   = (7'(tables_in_use) > 7'(MAX_TABLES)) ? 7'(MAX_TABLES) : 7'(tables_in_use);
		eff_col   = (result_columns > 3'(NL)) ? 3'(NL) : result_columns;
		bad_table = 7'(item_q.table_id) >= eff_tab;
		n_rows    = cnt_q[tix];
		tbase     = AW'(tix) * AW'(MAX_ROWS);
		colidx    = CLW'(item_q.column);
	end

	// Load: append one row unless the table id is out of range, the row is skipped or the table is full.
	always_comb begin
		vin     = {item_q.value_3, item_q.value_2, item_q.value_1, item_q.value_0};
		for (int c = 0; c < NL; c++) begin
			wword[c] = vin[c];
		end
		cur     = item_q.first_row ? '0 : n_rows;
		ld_full = cur >= CW'(MAX_ROWS);
		wr_en   = cmd.load && !bad_table && !item_q.row_unused && !ld_full;
		newcnt  = wr_en ? cur + CW'(1) : cur;
		wr_addr = tbase + AW'(cur[RW-1:0]);
		if (bad_table) begin
			ld_st = ST_BAD_TABLE;
		end else if (item_q.last_row && newcnt < CW'(2)) begin
			ld_st = ST_SHORT;
		end else if (item_q.row_unused) begin
			ld_st = ST_SKIPPED;
		end else if (ld_full) begin
			ld_st = ST_FULL;
		end else begin
			ld_st = ST_OK;
		end
	end

	// Query admission checks.
	always_comb begin
		if (bad_table) begin
			q_st = ST_BAD_TABLE;
		end else if ({1'b0, item_q.column} >= eff_col) begin
			q_st = ST_BAD_COL;
		end else if (!rdy_q[tix] || n_rows < CW'(2)) begin
			q_st = ST_SHORT;
		end else begin
			q_st = ST_OK;
		end
	end

	// Search pointer arithmetic and read row selection.
	always_comb begin
		mid = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
		if (lo_q < CW'(1)) begin
			iq = CW'(1);
		end else if (lo_q > n_rows - CW'(1)) begin
			iq = n_rows - CW'(1);
		end else begin
			iq = lo_q;
		end
		case (cmd.rd_sel)
			RA_ZERO: rd_row = '0;
			RA_LAST: rd_row = RW'(n_rows - CW'(1));
			RA_MID:  rd_row = RW'(mid);
			RA_IM1:  rd_row = RW'(iq - CW'(1));
			RA_I:    rd_row = RW'(iq);
			default: rd_row = '0;
		endcase
		rd_addr = tbase + AW'(rd_row);
		rd_val  = rd_word_q[colidx];
	end

	// Key and value stores, one row per address.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= item_q.key;
			val_mem[wr_addr] <= wword;
		end
		if (cmd.rd_en) begin
			rd_key_q  <= key_mem[rd_addr];
			rd_word_q <= val_mem[rd_addr];
		end
	end

	// Row counts and ready flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < MAX_TABLES; t++) begin
				cnt_q[t] <= '0;
				rdy_q[t] <= 1'b0;
			end
		end else if (cmd.load && !bad_table) begin
			cnt_q[tix] <= newcnt;
			rdy_q[tix] <= item_q.last_row && newcnt >= CW'(2);
		end
	end

	// Division step and multiplier operands.
	always_comb begin
		dx    = 33'(item_q.key) - 33'(xl_q);
		dd    = 33'(xr_q) - 33'(xl_q);
		t2    = {rem_q, 1'b0};
		ge    = t2 >= {1'b0, den_q};
		fa    = 18'(18'd65536 - {2'b00, tq_q});
		fb    = {2'b00, tq_q};
		sum_w = 35'(acc_q) + 35'(p_q >>> FRAC_W);
		if (sum_w > SAT_HI) begin
			sat_v = VAL_W'(SAT_HI);
		end else if (sum_w < SAT_LO) begin
			sat_v = VAL_W'(SAT_LO);
		end else begin
			sat_v = VAL_W'(sum_w);
		end
	end

	// Item, search, divider, multiplier and result registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_data;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= n_rows;
		end else if (cmd.srch_step) begin
			if (rd_key_q < item_q.key) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.cap_l) begin
			xl_q <= rd_key_q;
			yl_q <= rd_val;
		end
		if (cmd.cap_r) begin
			xr_q <= rd_key_q;
			yr_q <= rd_val;
		end
		if (cmd.div_init) begin
			rem_q  <= dx;
			den_q  <= dd;
			tq_q   <= '0;
			dcnt_q <= 5'd16;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? 33'(t2 - {1'b0, den_q}) : 33'(t2);
			tq_q   <= {tq_q[14:0], ge};
			dcnt_q <= dcnt_q - 5'd1;
		end
		if (cmd.mul1) begin
			p_q <= fa * yl_q;
		end else if (cmd.mul2) begin
			acc_q <= 34'(p_q >>> FRAC_W);
			p_q   <= fb * yr_q;
		end
		if (cmd.res_set) begin
			case (cmd.res_kind)
				RK_LOAD: res_q <= '{result_value: '0, status: ld_st};
				RK_QERR: res_q <= '{result_value: '0, status: q_st};
				RK_RDV:  res_q <= '{result_value: rd_val, status: ST_OK};
				RK_YL:   res_q <= '{result_value: yl_q, status: ST_OK};
				RK_YR:   res_q <= '{result_value: yr_q, status: ST_OK};
				RK_SUM:  res_q <= '{result_value: sat_v, status: ST_OK};
				default: res_q <= '{result_value: '0, status: ST_OK};
			endcase
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.is_query  = item_q.mode;
		sts.qerr      = q_st != ST_OK;
		sts.x_gt_rd   = item_q.key > rd_key_q;
		sts.x_lt_rd   = item_q.key < rd_key_q;
		sts.srch_done = lo_q >= hi_q;
		sts.l_short   = (item_q.key <= xl_q) || (xr_q <= xl_q);
		sts.x_ge_r    = item_q.key >= xr_q;
		sts.div_last  = dcnt_q == 5'd1;
	end

	assign res = res_q;

	// The search window never inverts.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.srch_step |=> lo_q <= hi_q)
		else $error("search window inverted");

	// The partial remainder stays below the divisor, so the quotient fits 16 bits.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_step |-> rem_q < den_q)
		else $error("divider remainder out of range");

	// Division starts only with x strictly inside the bracketing keys.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> (item_q.key > xl_q) && (item_q.key < xr_q))
		else $error("division started outside the interval");

endmodule

`default_nettype wire

// File: hdl/clamped_piecewise_linear_table.sv
// Top level of the clamped piecewise-linear table: configuration registers,
// output register and the controller/datapath pair. Depends on clpt_pkg, clpt_ctrl, clpt_dp.
`default_nettype none

// The block holds up to MAX_TABLES sub-tables of up to MAX_ROWS sorted rows, each
// row a Q16.16 key with up to four Q16.16 result columns. A load item (mode 0)
// appends at most one row and returns a status; a query item (mode 1) returns one
// column at x, clamped to the end rows and linearly interpolated inside the
// key range. One item is worked on at a time. An interpolating query makes at
// most floor(log2(rows))+1 binary search steps, each on the single store read
// port; the fraction comes from a 16-step radix-2 divider, and two multiplies
// share one multiplier. Stored rows are never cleared; there is no clearing
// pass after reset. The user is to write configuration only while the block is
// idle; the block itself does not enforce this.
module clamped_piecewise_linear_table
	import clpt_pkg::*;
#(
	parameter int MAX_TABLES  = 8,
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_index,
	input  wire logic [3:0] cfg_data
);

	logic [2:0] rcols_q;
	logic [3:0] ntab_q;
	logic       out_valid_q;
	out_item_t  out_data_q;
	logic       out_free, out_load;
	dp_cmd_t    cmd;
	dp_sts_t    sts;
	out_item_t  res;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcols_q <= 3'd1;
			ntab_q  <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RESULT_COLUMNS: rcols_q <= cfg_data[2:0];
				CFG_TABLES_IN_USE:  ntab_q  <= cfg_data;
				default:            ;
			endcase
		end
	end

	// Output register: holds a finished item until it is taken.
	assign out_free = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res;
		end
	end
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	clpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.out_load (out_load),
		.sts      (sts),
		.cmd      (cmd)
	);

	clpt_dp #(
		.MAX_TABLES  (MAX_TABLES),
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_data        (in_data),
		.result_columns (rcols_q),
		.tables_in_use  (ntab_q),
		.cmd            (cmd),
		.sts            (sts),
		.res            (res)
	);

endmodule

`default_nettype wire
